>>> rtl/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define SWDLS_CHECK(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("swdls check failed");

// consequence holds in the cycle after the antecedent
`define SWDLS_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swdls check failed");

`else

`define SWDLS_CHECK(label, cond)
`define SWDLS_CHECK_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/swdls_pkg.sv
package swdls_pkg;

   localparam int MAX_BITS = 32;
   localparam int CNT_W    = $clog2(MAX_BITS + 1);
   localparam int IDX_W    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
   localparam int COUNT_W  = 6;
   localparam int WORD_W   = 32;
   localparam int SAMPLE_W = 33;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_WRITE_PAR,
      OP_READ,
      OP_READ_PAR
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TURN,
      ST_DATA,
      ST_PARITY
   } state_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [COUNT_W-1:0]    bit_count;
      logic [WORD_W-1:0]     write_word;
      logic [SAMPLE_W-1:0]   line_samples;
   } req_type;

   typedef struct packed {
      logic                  turnaround_clock;
      logic                  drive_enable;
      logic                  line_out;
      logic [WORD_W-1:0]     read_word;
      logic                  parity_error;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic                  load;
      logic                  fire;
      logic                  last;
      state_type             pulse;
      logic [IDX_W-1:0]      idx;
   } seq_ctl_type;

   function automatic logic op_is_write(opcode_type op);
      return (op == OP_WRITE) || (op == OP_WRITE_PAR);
   endfunction

   function automatic logic op_has_parity(opcode_type op);
      return (op == OP_WRITE_PAR) || (op == OP_READ_PAR);
   endfunction

endpackage

>>> rtl/swdls_seq.sv
module swdls_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  swdls_pkg::req_type       req_item,
   input  logic                     slot_free,
   output logic                     req_ready,
   output swdls_pkg::seq_ctl_type   ctl
);
   import swdls_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               driven_ff, driven_in;
   logic               par_en_ff, par_en_in;

   logic               accept;
   logic               want;
   logic               with_par;
   logic [CNT_W-1:0]   n_clamp;
   logic               data_end;
   logic               fire;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign want     = op_is_write(req_item.opcode);
   assign with_par = op_has_parity(req_item.opcode);
   assign n_clamp  = (req_item.bit_count > COUNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS)
                                                              : CNT_W'(req_item.bit_count);
   assign data_end = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff);
   assign fire     = (state_ff != ST_IDLE) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (want != driven_ff)   state_in = ST_TURN;
               else if (n_clamp != '0)  state_in = ST_DATA;
               else if (with_par)       state_in = ST_PARITY;
               else                     state_in = ST_IDLE;
            end
         end
         ST_TURN: begin
            if (slot_free) begin
               if (n_ff != '0)     state_in = ST_DATA;
               else if (par_en_ff) state_in = ST_PARITY;
               else                state_in = ST_IDLE;
            end
         end
         ST_DATA: begin
            if (slot_free && data_end) state_in = par_en_ff ? ST_PARITY : ST_IDLE;
         end
         ST_PARITY: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      n_in      = n_ff;
      idx_in    = idx_ff;
      driven_in = driven_ff;
      par_en_in = par_en_ff;
      if (accept) begin
         n_in      = n_clamp;
         idx_in    = '0;
         driven_in = want;
         par_en_in = with_par;
      end else if (fire && (state_ff == ST_DATA)) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      ctl.load  = accept;
      ctl.fire  = fire;
      ctl.pulse = state_ff;
      ctl.idx   = idx_ff;
      case (state_ff)
         ST_TURN:   ctl.last = (n_ff == '0) && !par_en_ff;
         ST_DATA:   ctl.last = data_end && !par_en_ff;
         ST_PARITY: ctl.last = 1'b1;
         default:   ctl.last = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         driven_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         driven_ff <= driven_in;
      end
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      par_en_ff <= par_en_in;
   end

endmodule

>>> rtl/swdls_shift.sv
module swdls_shift (
   input  logic                     clock,
   input  swdls_pkg::req_type       req_item,
   input  swdls_pkg::seq_ctl_type   ctl,
   output swdls_pkg::rsp_type       result
);
   import swdls_pkg::*;

   logic [WORD_W-1:0]    wr_ff, wr_in;
   logic [SAMPLE_W-1:0]  smp_ff, smp_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic                 par_ff, par_in;
   logic                 rd_ff, rd_in;
   logic                 chk_ff, chk_in;
   logic                 cur_bit;
   logic                 data_step;

   assign cur_bit   = rd_ff ? smp_ff[0] : wr_ff[0];
   assign data_step = ctl.fire && (ctl.pulse == ST_DATA);

   // read bit lands at its own position of the word
   always_comb begin
      word_in = word_ff;
      if (rd_ff && (ctl.pulse == ST_DATA)) word_in[ctl.idx] = smp_ff[0];
   end

   always_comb begin
      wr_in  = wr_ff;
      smp_in = smp_ff;
      par_in = par_ff;
      rd_in  = rd_ff;
      chk_in = chk_ff;
      if (ctl.load) begin
         wr_in  = req_item.write_word;
         smp_in = req_item.line_samples;
         par_in = 1'b0;
         rd_in  = !op_is_write(req_item.opcode);
         chk_in = op_has_parity(req_item.opcode);
      end else if (data_step) begin
         wr_in  = wr_ff >> 1;
         smp_in = smp_ff >> 1;
         par_in = par_ff ^ cur_bit;
      end
   end

   always_comb begin
      result      = '0;
      result.last = ctl.last;
      case (ctl.pulse)
         ST_TURN: result.turnaround_clock = 1'b1;
         ST_DATA: begin
            result.drive_enable = !rd_ff;
            result.line_out     = !rd_ff && wr_ff[0];
         end
         ST_PARITY: begin
            result.drive_enable = !rd_ff;
            result.line_out     = !rd_ff && par_ff;
         end
         default: result.turnaround_clock = 1'b0;
      endcase
      if (rd_ff && ctl.last) begin
         result.read_word    = word_in;
         // after the data shifts, bit 0 of the sample register is the parity pulse
         result.parity_error = chk_ff && (ctl.pulse == ST_PARITY) && (par_ff ^ smp_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      wr_ff  <= wr_in;
      smp_ff <= smp_in;
      par_ff <= par_in;
      rd_ff  <= rd_in;
      chk_ff <= chk_in;
      if (ctl.load)       word_ff <= '0;
      else if (data_step) word_ff <= word_in;
   end

endmodule

>>> rtl/swd_line_shifter.sv
// serial wire debug line shifter
// req channel: one line operation per transfer (opcode, bit_count, write_word,
// line_samples). rsp channel: one transfer per clock pulse on the wire, giving
// turnaround_clock, drive_enable, line_out, and on the final pulse (last) the
// assembled read_word and parity_error of a read.
// an operation yields an optional turnaround pulse when the line direction
// changes, bit_count data pulses (clamped to 32) and an optional parity pulse:
// 0 to 34 results. the first result leaves through the result register once the
// sequencer has left idle, then one result per cycle while the receiver keeps
// rsp_ready high. one operation is handled at a time: req_ready stays low until
// the last pulse fires; the sequencer steps the data shift registers one bit
// per cycle while the result slot is free. with no pulses req_ready stays high.
// a stalled receiver holds the result register and the sequencer waits on it.
// reset releases the line (next write starts with a turnaround) and empties
// the result register.
`include "assert_macros.svh"

module swd_line_shifter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  swdls_pkg::req_type   req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output swdls_pkg::rsp_type   rsp_item
);
   import swdls_pkg::*;

   seq_ctl_type   ctl;
   rsp_type       result;
   rsp_type       rsp_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   swdls_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .slot_free (slot_free),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   swdls_shift u_shift (
      .clock    (clock),
      .req_item (req_item),
      .ctl      (ctl),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.fire)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (ctl.fire) rsp_item_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // released line never carries a high level
   `SWDLS_CHECK(a_released_low, !(rsp_valid_ff && !rsp_item_ff.drive_enable && rsp_item_ff.line_out))
   // read data only shows up on the closing pulse
   `SWDLS_CHECK(a_word_on_last, !(rsp_valid_ff && (rsp_item_ff.read_word != '0) && !rsp_item_ff.last))
   // closing pulse frees the sequencer for the next operation
   `SWDLS_CHECK_NEXT(a_last_frees, ctl.fire && ctl.last, req_ready)

endmodule

>>> bench/swd_line_shifter_test.sv
module swd_line_shifter_test;
   import swdls_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int ITEMS_PER_RUN = 30;

   // expected pulse stream of the shifter, with its own copy of the line direction
   class pulse_tracker;
      bit      host_drives;
      rsp_type expected_pulses[$];
      int      mismatches;

      function new();
         host_drives = 1'b0;
         mismatches = 0;
      endfunction

      function void note_operation(req_type op_req);
         int unsigned n;
         bit          to_write;
         bit          has_par;
         bit          par;
         logic [WORD_W-1:0] word;
         rsp_type     pulse;
         rsp_type     batch[$];
         n = (op_req.bit_count > MAX_BITS) ? MAX_BITS : op_req.bit_count;
         to_write = (op_req.opcode == OP_WRITE) || (op_req.opcode == OP_WRITE_PAR);
         has_par = (op_req.opcode == OP_WRITE_PAR) || (op_req.opcode == OP_READ_PAR);
         par = 1'b0;
         word = '0;
         // direction change: one released pulse first
         if (host_drives != to_write) begin
            pulse = '0;
            pulse.turnaround_clock = 1'b1;
            batch.push_back(pulse);
            host_drives = to_write;
         end
         for (int i = 0; i < n; i++) begin
            pulse = '0;
            if (to_write) begin
               pulse.drive_enable = 1'b1;
               pulse.line_out = op_req.write_word[i];
               par ^= op_req.write_word[i];
            end else begin
               word[i] = op_req.line_samples[i];
               par ^= op_req.line_samples[i];
            end
            batch.push_back(pulse);
         end
         if (has_par) begin
            pulse = '0;
            if (to_write) begin
               pulse.drive_enable = 1'b1;
               pulse.line_out = par;
            end else begin
               par ^= op_req.line_samples[n];
            end
            batch.push_back(pulse);
         end
         if (batch.size() > 0) begin
            pulse = batch.pop_back();
            if (!to_write) begin
               pulse.read_word = word;
               pulse.parity_error = has_par & par;
            end
            pulse.last = 1'b1;
            batch.push_back(pulse);
         end
         foreach (batch[i]) expected_pulses.push_back(batch[i]);
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pulse(rsp_type got);
         rsp_type want;
         if (expected_pulses.size() == 0) begin
            $error("result transfer with nothing expected: 0x%0h", got);
            mismatches++;
            return;
         end
         want = expected_pulses.pop_front();
         compare_field("turnaround_clock", want.turnaround_clock, got.turnaround_clock);
         compare_field("drive_enable", want.drive_enable, got.drive_enable);
         compare_field("line_out", want.line_out, got.line_out);
         compare_field("read_word", want.read_word, got.read_word);
         compare_field("parity_error", want.parity_error, got.parity_error);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_item;

   pulse_tracker tracker;
   int send_idle_pct;
   int stall_pct;
   bit hold_req;
   int hold_left;
   int cycle_count;

   swd_line_shifter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req = 1'b0;
      hold_left = 0;
      cycle_count = 0;
      tracker = new();
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_pulse(rsp_item);
   end

   function automatic req_type make_request(opcode_type op, logic [COUNT_W-1:0] count,
                                            logic [WORD_W-1:0] word,
                                            logic [SAMPLE_W-1:0] samples);
      req_type r;
      r.opcode = op;
      r.bit_count = count;
      r.write_word = word;
      r.line_samples = samples;
      return r;
   endfunction

   function automatic req_type random_request();
      int unsigned pick;
      logic [COUNT_W-1:0] count;
      pick = $urandom_range(99);
      if (pick < 10) count = '0;
      else if (pick < 20) count = COUNT_W'($urandom_range(63, MAX_BITS + 1));
      else count = COUNT_W'($urandom_range(MAX_BITS, 1));
      return make_request(opcode_type'($urandom_range(3)), count, $urandom,
                          {1'($urandom_range(1)), 32'($urandom)});
   endfunction

   // returns just after the transfer edge, valid still high
   task automatic send_request(req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!req_ready);
      tracker.note_operation(r);
   endtask

   task automatic send_random(int count);
      repeat (count) send_request(random_request());
   endtask

   initial begin
      req_type directed[$];
      #0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // line starts released: first write turns the line around
      directed.push_back(make_request(OP_WRITE, 6'd0, 32'h0, 33'h0));
      directed.push_back(make_request(OP_WRITE, 6'd0, 32'h0, 33'h0));
      directed.push_back(make_request(OP_WRITE_PAR, 6'd32, 32'hFFFF_FFFF, 33'h0));
      directed.push_back(make_request(OP_WRITE_PAR, 6'd32, 32'h0, 33'h1_FFFF_FFFF));
      directed.push_back(make_request(OP_WRITE, 6'd63, 32'hA5A5_5A5A, 33'h0));
      directed.push_back(make_request(OP_WRITE_PAR, 6'd33, 32'h1234_5679, 33'h0));
      directed.push_back(make_request(OP_READ, 6'd0, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF));
      directed.push_back(make_request(OP_READ, 6'd0, 32'h0, 33'h1_FFFF_FFFF));
      directed.push_back(make_request(OP_READ_PAR, 6'd0, 32'h0, 33'h1));
      directed.push_back(make_request(OP_READ_PAR, 6'd0, 32'h0, 33'h0));
      directed.push_back(make_request(OP_READ_PAR, 6'd32, 32'h0, 33'h0_FFFF_FFFF));
      directed.push_back(make_request(OP_READ_PAR, 6'd32, 32'h0, 33'h1_FFFF_FFFF));
      directed.push_back(make_request(OP_READ, 6'd32, 32'hFFFF_FFFF, 33'h0));
      directed.push_back(make_request(OP_READ_PAR, 6'd63, 32'h0, 33'h1_8000_0001));
      directed.push_back(make_request(OP_READ, 6'd1, 32'h0, 33'h1));
      directed.push_back(make_request(OP_WRITE_PAR, 6'd0, 32'h0, 33'h0));
      directed.push_back(make_request(OP_WRITE, 6'd1, 32'h1, 33'h0));
      directed.push_back(make_request(OP_READ_PAR, 6'd5, 32'h0, 33'h0_0000_0035));
      directed.push_back(make_request(OP_WRITE_PAR, 6'd7, 32'h0000_004B, 33'h0));
      foreach (directed[i]) send_request(directed[i]);

      send_random(ITEMS_PER_RUN);
      send_idle_pct = 77;
      send_random(ITEMS_PER_RUN);
      send_idle_pct = 0;
      stall_pct = 77;
      send_random(ITEMS_PER_RUN);

      // receiver holds off while requests keep coming, backing up the input
      stall_pct = 0;
      hold_req = 1'b1;
      send_random(12);

      send_idle_pct = 20;
      stall_pct = 20;
      send_random(ITEMS_PER_RUN);

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_pulses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_pulses.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
